@@ hw/rtl/svpwm_duty_calculator_top_macros.svh @@
// Assertion macros used by the checker file of the duty calculator.
`ifndef SVPWM_DUTY_CALCULATOR_TOP_MACROS_SVH
`define SVPWM_DUTY_CALCULATOR_TOP_MACROS_SVH

// Clocked assertion, muted while reset is low.
`define SVPWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs through reset.
`define SVPWM_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/svpwm_pkg.sv @@
// Shared widths, constants and types of the space vector PWM duty calculator.
package svpwm_pkg;

    localparam int IN_W       = 16;
    localparam int DUTY_W     = 16;
    localparam int SEC_W      = 3;
    localparam int P_W        = 35;
    localparam int Q_W        = 32;
    localparam int T_W        = 33;
    localparam int Z_W        = 31;
    localparam int D_W        = 35;
    localparam int NUM_W      = 64;
    localparam int QUO_W      = 32;
    localparam int REM_W      = T_W + 1;
    localparam int DIV_STAGES = 16;
    localparam int DIV_STEP   = QUO_W / DIV_STAGES;
    localparam int Q30_SH     = 30;
    localparam int Q15_SH     = 16;

    localparam int IN_TDATA_W  = 2 * IN_W;
    localparam int OUT_FIELD_W = 3 * DUTY_W + SEC_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic signed [18:0] SQRT3_Q16 = 19'sd113512;
    localparam logic [T_W-1:0]     ONE_Q30   = 33'd1073741824;
    localparam logic [D_W-1:0]     ROUND_Q31 = 35'd32768;
    localparam logic [DUTY_W-1:0]  DUTY_FULL = 16'd32768;

    localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
    localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
    localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
    localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
    localparam logic [SEC_W-1:0] SEC_5 = 3'd5;
    localparam logic [SEC_W-1:0] SEC_6 = 3'd6;

    typedef struct packed {
        logic [T_W-1:0]   ta;
        logic [T_W-1:0]   tb;
        logic [T_W-1:0]   tab;
        logic [SEC_W-1:0] sector;
        logic             om;
    } t_side;

endpackage

@@ hw/rtl/svpwm_duty_calculator_top.sv @@
// Top level of the space vector PWM duty calculator.
//
//   port group  dir  tdata fields (low bit first)
//   s_axis      in   alpha[15:0], beta[31:16]
//   m_axis      out  duty_u[15:0], duty_v[31:16], duty_w[47:32], sector[50:48],
//                    overmodulated[51], zero pad[55:52]
//
// One beat per cycle while m_axis is not stalled: 3 front stages (multiply,
// sector and times, divider operands), 16 divider stages of 2 quotient bits, 2 back stages.
// Synchronous reset empties every stage; no clearing pass.
// Each stage holds its beat while the one after it is full and stalled; bubbles fill up.
module svpwm_duty_calculator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // alpha, beta
    input  logic [svpwm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // duty_u, duty_v, duty_w, sector, overmodulated, zero pad
    output logic [svpwm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic                          w_f_valid, w_f_ready;
    logic [svpwm_pkg::NUM_W-1:0]   w_f_num;
    svpwm_pkg::t_side              w_f_side;

    logic                          w_d_valid, w_d_ready;
    logic [svpwm_pkg::QUO_W-1:0]   w_d_quo;
    logic                          w_d_rem_zero;
    svpwm_pkg::t_side              w_d_side;

    logic [svpwm_pkg::DUTY_W-1:0]  w_du, w_dv, w_dw;
    logic [svpwm_pkg::SEC_W-1:0]   w_sec;
    logic                          w_om;

    svpwm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_alpha ($signed(s_axis_tdata[svpwm_pkg::IN_W-1:0])),
        .i_beta  ($signed(s_axis_tdata[svpwm_pkg::IN_TDATA_W-1:svpwm_pkg::IN_W])),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_num   (w_f_num),
        .o_side  (w_f_side)
    );

    svpwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_f_valid),
        .o_ready    (w_f_ready),
        .i_num      (w_f_num),
        .i_side     (w_f_side),
        .o_valid    (w_d_valid),
        .i_ready    (w_d_ready),
        .o_quo      (w_d_quo),
        .o_rem_zero (w_d_rem_zero),
        .o_side     (w_d_side)
    );

    svpwm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_d_valid),
        .o_ready    (w_d_ready),
        .i_quo      (w_d_quo),
        .i_rem_zero (w_d_rem_zero),
        .i_side     (w_d_side),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_duty_u   (w_du),
        .o_duty_v   (w_dv),
        .o_duty_w   (w_dw),
        .o_sector   (w_sec),
        .o_om       (w_om)
    );

    assign m_axis_tdata = {
        {(svpwm_pkg::OUT_TDATA_W - svpwm_pkg::OUT_FIELD_W){1'b0}},
        w_om, w_sec, w_dw, w_dv, w_du
    };

endmodule

@@ hw/rtl/svpwm_front.sv @@
// Front stages: sqrt3 product, sector search, active times and divider operands.
module svpwm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [svpwm_pkg::IN_W-1:0]   i_alpha,
    input  logic signed [svpwm_pkg::IN_W-1:0]   i_beta,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [svpwm_pkg::NUM_W-1:0]         o_num,
    output svpwm_pkg::t_side                    o_side
);

    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;

    logic signed [svpwm_pkg::P_W-1:0] r_p;
    logic signed [svpwm_pkg::Q_W-1:0] r_q;
    logic signed [svpwm_pkg::P_W-1:0] n_p;
    logic signed [svpwm_pkg::Q_W-1:0] n_q;

    logic signed [svpwm_pkg::P_W-1:0] w_q;
    logic signed [svpwm_pkg::P_W-1:0] w_pmq, w_ppq, w_mpmq, w_qmp, w_q2, w_mq2;
    logic signed [svpwm_pkg::P_W-1:0] w_ta, w_tb, w_tab;

    logic [svpwm_pkg::T_W-1:0]   r_ta, r_tb, r_tab;
    logic [svpwm_pkg::SEC_W-1:0] r_sec;
    logic [svpwm_pkg::T_W-1:0]   n_ta, n_tb, n_tab;
    logic [svpwm_pkg::SEC_W-1:0] n_sec;

    logic [svpwm_pkg::NUM_W-1:0] r_num;
    svpwm_pkg::t_side            r_side;
    logic [svpwm_pkg::NUM_W-1:0] n_num;
    svpwm_pkg::t_side            n_side;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v3;
    assign o_num   = r_num;
    assign o_side  = r_side;

    assign n_p = svpwm_pkg::P_W'(i_alpha) * svpwm_pkg::P_W'(svpwm_pkg::SQRT3_Q16);
    assign n_q = {i_beta, {(svpwm_pkg::Q_W - svpwm_pkg::IN_W){1'b0}}};

    assign w_q    = {{(svpwm_pkg::P_W - svpwm_pkg::Q_W){r_q[svpwm_pkg::Q_W-1]}}, r_q};
    assign w_pmq  = r_p - w_q;
    assign w_ppq  = r_p + w_q;
    assign w_mpmq = -r_p - w_q;
    assign w_qmp  = w_q - r_p;
    assign w_q2   = w_q <<< 1;
    assign w_mq2  = -w_q2;

    always_comb begin
        priority if (!r_q[svpwm_pkg::Q_W-1]) begin
            if (!w_pmq[svpwm_pkg::P_W-1]) begin
                n_sec = svpwm_pkg::SEC_1;
            end else if (!w_mpmq[svpwm_pkg::P_W-1]) begin
                n_sec = svpwm_pkg::SEC_3;
            end else begin
                n_sec = svpwm_pkg::SEC_2;
            end
        end else begin
            if (w_pmq[svpwm_pkg::P_W-1]) begin
                n_sec = svpwm_pkg::SEC_4;
            end else if (w_mpmq[svpwm_pkg::P_W-1]) begin
                n_sec = svpwm_pkg::SEC_6;
            end else begin
                n_sec = svpwm_pkg::SEC_5;
            end
        end
    end

    always_comb begin
        unique case (n_sec)
            svpwm_pkg::SEC_1: begin
                w_ta = w_pmq;  w_tb = w_q2;   w_tab = w_ppq;
            end
            svpwm_pkg::SEC_2: begin
                w_ta = w_ppq;  w_tb = w_qmp;  w_tab = w_q2;
            end
            svpwm_pkg::SEC_3: begin
                w_ta = w_q2;   w_tb = w_mpmq; w_tab = w_qmp;
            end
            svpwm_pkg::SEC_4: begin
                w_ta = w_qmp;  w_tb = w_mq2;  w_tab = w_mpmq;
            end
            svpwm_pkg::SEC_5: begin
                w_ta = w_mpmq; w_tb = w_pmq;  w_tab = w_mq2;
            end
            svpwm_pkg::SEC_6: begin
                w_ta = w_mq2;  w_tb = w_ppq;  w_tab = w_pmq;
            end
            default: begin
                w_ta = '0;     w_tb = '0;     w_tab = '0;
            end
        endcase
    end

    assign n_ta  = w_ta[svpwm_pkg::T_W-1:0];
    assign n_tb  = w_tb[svpwm_pkg::T_W-1:0];
    assign n_tab = w_tab[svpwm_pkg::T_W-1:0];

    assign n_num = (svpwm_pkg::NUM_W'(r_ta) << svpwm_pkg::Q30_SH)
                 + svpwm_pkg::NUM_W'(r_tab >> 1);

    always_comb begin
        n_side.ta     = r_ta;
        n_side.tb     = r_tb;
        n_side.tab    = r_tab;
        n_side.sector = r_sec;
        n_side.om     = (r_tab > svpwm_pkg::ONE_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_p <= n_p;
            r_q <= n_q;
        end
        if (w_en2) begin
            r_ta  <= n_ta;
            r_tb  <= n_tb;
            r_tab <= n_tab;
            r_sec <= n_sec;
        end
        if (w_en3) begin
            r_num  <= n_num;
            r_side <= n_side;
        end
    end

endmodule

@@ hw/rtl/svpwm_div.sv @@
// Pipelined restoring divider for the overmodulation rescale, two quotient bits a stage.
module svpwm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [svpwm_pkg::NUM_W-1:0]  i_num,
    input  svpwm_pkg::t_side             i_side,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [svpwm_pkg::QUO_W-1:0]  o_quo,
    output logic                         o_rem_zero,
    output svpwm_pkg::t_side             o_side
);

    logic [svpwm_pkg::DIV_STAGES-1:0] r_v;
    logic [svpwm_pkg::DIV_STAGES-1:0] w_v_in;
    logic [svpwm_pkg::DIV_STAGES-1:0] w_en;
    logic [svpwm_pkg::DIV_STAGES-1:0] w_en_nxt;

    logic [svpwm_pkg::REM_W-1:0] r_rem    [svpwm_pkg::DIV_STAGES];
    logic [svpwm_pkg::QUO_W-1:0] r_low    [svpwm_pkg::DIV_STAGES];
    logic [svpwm_pkg::QUO_W-1:0] r_quo    [svpwm_pkg::DIV_STAGES];
    svpwm_pkg::t_side            r_side   [svpwm_pkg::DIV_STAGES];

    logic [svpwm_pkg::REM_W-1:0] w_rem_in  [svpwm_pkg::DIV_STAGES];
    logic [svpwm_pkg::QUO_W-1:0] w_low_in  [svpwm_pkg::DIV_STAGES];
    logic [svpwm_pkg::QUO_W-1:0] w_quo_in  [svpwm_pkg::DIV_STAGES];
    svpwm_pkg::t_side            w_side_in [svpwm_pkg::DIV_STAGES];

    logic [svpwm_pkg::REM_W-1:0] n_rem [svpwm_pkg::DIV_STAGES];
    logic [svpwm_pkg::QUO_W-1:0] n_low [svpwm_pkg::DIV_STAGES];
    logic [svpwm_pkg::QUO_W-1:0] n_quo [svpwm_pkg::DIV_STAGES];

    for (genvar g = 0; g < svpwm_pkg::DIV_STAGES; g++) begin : g_link
        if (g == 0) begin : g_head
            assign w_rem_in[g]  = svpwm_pkg::REM_W'(
                i_num[svpwm_pkg::NUM_W-1 -: svpwm_pkg::QUO_W]);
            assign w_low_in[g]  = i_num[svpwm_pkg::QUO_W-1:0];
            assign w_quo_in[g]  = '0;
            assign w_side_in[g] = i_side;
            assign w_v_in[g]    = i_valid;
        end else begin : g_body
            assign w_rem_in[g]  = r_rem[g-1];
            assign w_low_in[g]  = r_low[g-1];
            assign w_quo_in[g]  = r_quo[g-1];
            assign w_side_in[g] = r_side[g-1];
            assign w_v_in[g]    = r_v[g-1];
        end
        if (g == svpwm_pkg::DIV_STAGES - 1) begin : g_tail
            assign w_en_nxt[g] = i_ready;
        end else begin : g_mid
            assign w_en_nxt[g] = w_en[g+1];
        end
        assign w_en[g] = !r_v[g] || w_en_nxt[g];
    end

    always_comb begin
        logic [svpwm_pkg::REM_W-1:0] rem;
        logic [svpwm_pkg::REM_W-1:0] sh;
        logic [svpwm_pkg::REM_W-1:0] den;
        logic [svpwm_pkg::QUO_W-1:0] low;
        logic [svpwm_pkg::QUO_W-1:0] quo;
        for (int s = 0; s < svpwm_pkg::DIV_STAGES; s++) begin
            rem = w_rem_in[s];
            low = w_low_in[s];
            quo = w_quo_in[s];
            den = {1'b0, w_side_in[s].tab};
            for (int b = 0; b < svpwm_pkg::DIV_STEP; b++) begin
                sh  = {rem[svpwm_pkg::REM_W-2:0], low[svpwm_pkg::QUO_W-1]};
                low = {low[svpwm_pkg::QUO_W-2:0], 1'b0};
                if (sh >= den) begin
                    rem = sh - den;
                    quo = {quo[svpwm_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    rem = sh;
                    quo = {quo[svpwm_pkg::QUO_W-2:0], 1'b0};
                end
            end
            n_rem[s] = rem;
            n_low[s] = low;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < svpwm_pkg::DIV_STAGES; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= w_v_in[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < svpwm_pkg::DIV_STAGES; s++) begin
            if (w_en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_low[s]  <= n_low[s];
                r_quo[s]  <= n_quo[s];
                r_side[s] <= w_side_in[s];
            end
        end
    end

    assign o_ready    = w_en[0];
    assign o_valid    = r_v[svpwm_pkg::DIV_STAGES-1];
    assign o_quo      = r_quo[svpwm_pkg::DIV_STAGES-1];
    assign o_rem_zero = (r_rem[svpwm_pkg::DIV_STAGES-1] == '0);
    assign o_side     = r_side[svpwm_pkg::DIV_STAGES-1];

endmodule

@@ hw/rtl/svpwm_back.sv @@
// Back stages: rescaled times, zero-vector share, phase duties with rounding and clamp.
module svpwm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [svpwm_pkg::QUO_W-1:0]   i_quo,
    input  logic                          i_rem_zero,
    input  svpwm_pkg::t_side              i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [svpwm_pkg::DUTY_W-1:0]  o_duty_u,
    output logic [svpwm_pkg::DUTY_W-1:0]  o_duty_v,
    output logic [svpwm_pkg::DUTY_W-1:0]  o_duty_w,
    output logic [svpwm_pkg::SEC_W-1:0]   o_sector,
    output logic                          o_om
);

    function automatic logic [svpwm_pkg::DUTY_W-1:0] to_duty(
        input logic [svpwm_pkg::T_W-1:0] x,
        input logic [svpwm_pkg::Z_W-1:0] z
    );
        logic [svpwm_pkg::D_W-1:0] d;
        logic [svpwm_pkg::D_W-1:0] r;
        d = svpwm_pkg::D_W'(z) + (svpwm_pkg::D_W'(x) << 1) + svpwm_pkg::ROUND_Q31;
        r = d >> svpwm_pkg::Q15_SH;
        if (r > svpwm_pkg::D_W'(svpwm_pkg::DUTY_FULL)) begin
            return svpwm_pkg::DUTY_FULL;
        end
        return r[svpwm_pkg::DUTY_W-1:0];
    endfunction

    logic r_vld1, r_vld2;
    logic w_en1, w_en2;

    logic                        w_inc;
    logic [svpwm_pkg::T_W-1:0]   n_ta, n_tb, n_sum;
    logic [svpwm_pkg::Z_W-1:0]   n_z;
    logic [svpwm_pkg::T_W-1:0]   r_ta, r_tb, r_sum;
    logic [svpwm_pkg::Z_W-1:0]   r_z;
    logic [svpwm_pkg::SEC_W-1:0] r_sec;
    logic                        r_om;

    logic [svpwm_pkg::T_W-1:0]    w_xu, w_xv, w_xw;
    logic [svpwm_pkg::DUTY_W-1:0] r_du, r_dv, r_dw;
    logic [svpwm_pkg::SEC_W-1:0]  r_sec_out;
    logic                         r_om_out;

    assign w_en2   = !r_vld2 || i_ready;
    assign w_en1   = !r_vld1 || w_en2;
    assign o_ready = w_en1;

    assign w_inc = !i_side.tab[0] && i_rem_zero;

    always_comb begin
        if (i_side.om) begin
            n_ta  = svpwm_pkg::T_W'(i_quo);
            n_tb  = svpwm_pkg::ONE_Q30 - svpwm_pkg::T_W'(i_quo) + svpwm_pkg::T_W'(w_inc);
            n_sum = svpwm_pkg::ONE_Q30 + svpwm_pkg::T_W'(w_inc);
            n_z   = '0;
        end else begin
            n_ta  = i_side.ta;
            n_tb  = i_side.tb;
            n_sum = i_side.tab;
            n_z   = svpwm_pkg::Z_W'(svpwm_pkg::ONE_Q30 - i_side.tab);
        end
    end

    always_comb begin
        unique case (r_sec)
            svpwm_pkg::SEC_1: begin
                w_xu = r_sum; w_xv = r_tb;  w_xw = '0;
            end
            svpwm_pkg::SEC_2: begin
                w_xu = r_ta;  w_xv = r_sum; w_xw = '0;
            end
            svpwm_pkg::SEC_3: begin
                w_xu = '0;    w_xv = r_sum; w_xw = r_tb;
            end
            svpwm_pkg::SEC_4: begin
                w_xu = '0;    w_xv = r_ta;  w_xw = r_sum;
            end
            svpwm_pkg::SEC_5: begin
                w_xu = r_tb;  w_xv = '0;    w_xw = r_sum;
            end
            svpwm_pkg::SEC_6: begin
                w_xu = r_sum; w_xv = '0;    w_xw = r_ta;
            end
            default: begin
                w_xu = '0;    w_xv = '0;    w_xw = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_vld1 <= i_valid;
            end
            if (w_en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_ta  <= n_ta;
            r_tb  <= n_tb;
            r_sum <= n_sum;
            r_z   <= n_z;
            r_sec <= i_side.sector;
            r_om  <= i_side.om;
        end
        if (w_en2) begin
            r_du      <= to_duty(w_xu, r_z);
            r_dv      <= to_duty(w_xv, r_z);
            r_dw      <= to_duty(w_xw, r_z);
            r_sec_out <= r_sec;
            r_om_out  <= r_om;
        end
    end

    assign o_valid  = r_vld2;
    assign o_duty_u = r_du;
    assign o_duty_v = r_dv;
    assign o_duty_w = r_dw;
    assign o_sector = r_sec_out;
    assign o_om     = r_om_out;

endmodule

@@ hw/rtl/svpwm_checker.sv @@
// Port-level checker of the duty calculator output channel, bound to the top level.
`include "svpwm_duty_calculator_top_macros.svh"

module svpwm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_tvalid,
    input logic                               i_tready,
    input logic [svpwm_pkg::OUT_TDATA_W-1:0]  i_tdata
);

    logic [svpwm_pkg::DUTY_W-1:0] w_du, w_dv, w_dw;
    logic                         w_om;

    assign w_du = i_tdata[svpwm_pkg::DUTY_W-1:0];
    assign w_dv = i_tdata[2*svpwm_pkg::DUTY_W-1:svpwm_pkg::DUTY_W];
    assign w_dw = i_tdata[3*svpwm_pkg::DUTY_W-1:2*svpwm_pkg::DUTY_W];
    assign w_om = i_tdata[svpwm_pkg::OUT_FIELD_W-1];

    `SVPWM_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !i_tvalid, "beat out right after reset")
    `SVPWM_ASSERT(a_stall_holds, i_clk, i_rst_n, i_tvalid && !i_tready |=> i_tvalid && $stable(i_tdata), "stalled beat changed")
    `SVPWM_ASSERT(a_duty_range, i_clk, i_rst_n, i_tvalid |-> w_du <= svpwm_pkg::DUTY_FULL && w_dv <= svpwm_pkg::DUTY_FULL && w_dw <= svpwm_pkg::DUTY_FULL, "duty above full scale")
    `SVPWM_ASSERT(a_om_zero_phase, i_clk, i_rst_n, i_tvalid && w_om |-> w_du == '0 || w_dv == '0 || w_dw == '0, "overmodulated beat without a zero duty")

endmodule

bind svpwm_duty_calculator_top svpwm_checker u_svpwm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (m_axis_tvalid),
    .i_tready (m_axis_tready),
    .i_tdata  (m_axis_tdata)
);
